[rtl/tmdg_pkg.sv]
package tmdg_pkg;

  localparam int CircleSteps = 16;
  localparam int TableLen    = 16;
  localparam int StepW       = $clog2(CircleSteps);
  localparam int TableIdxW   = $clog2(TableLen);
  localparam int DeltaW      = 5;
  localparam int RawW        = 16;
  localparam int TimeW       = 32;
  localparam int CfgIdxW     = 3;
  localparam int CfgDataW    = 16;
  localparam int InDataW     = 40;
  localparam int OutDataW    = 16;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEAD_ZONE     = 3'd0,
    REG_SLOW_LIMIT    = 3'd1,
    REG_MEDIUM_LIMIT  = 3'd2,
    REG_FAST_LIMIT    = 3'd3,
    REG_DEBOUNCE_MS   = 3'd4,
    REG_REPORT_PERIOD = 3'd5,
    REG_CIRCLE_PERIOD = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] dead_zone;
    logic [15:0] slow_limit;
    logic [15:0] medium_limit;
    logic [15:0] fast_limit;
    logic [15:0] debounce_ms;
    logic [9:0]  report_period;
    logic [13:0] circle_period;
  } cfg_t;

  typedef logic signed [DeltaW-1:0] delta_t;

  localparam delta_t RingDx [TableLen] = '{
    5'sd2, 5'sd2, 5'sd1, 5'sd0, -5'sd1, -5'sd2, -5'sd2, -5'sd2,
    -5'sd2, -5'sd2, -5'sd1, 5'sd0, 5'sd1, 5'sd2, 5'sd2, 5'sd2
  };
  localparam delta_t RingDy [TableLen] = '{
    5'sd0, 5'sd1, 5'sd2, 5'sd2, 5'sd2, 5'sd1, 5'sd0, -5'sd1,
    -5'sd2, -5'sd2, -5'sd2, -5'sd2, -5'sd2, -5'sd1, 5'sd0, 5'sd1
  };

  // Stretches or samples the circle table to the number of steps.
  function automatic logic [TableIdxW-1:0] ring_index(input logic [StepW-1:0] step);
    ring_index = TableIdxW'((int'(step) * TableLen) / CircleSteps);
  endfunction

endpackage

[rtl/tilt_mouse_delta_generator.sv]
// Tilt mouse delta generator. Each input item is one millisecond tick and gives
// exactly one output item; a new tick is taken every cycle while the output side
// keeps up. The button edge and debounce, the report slot, the tilt quantizer and
// the circle table are all worked out in one pass between the input register and
// the output register, so throughput is one item per cycle. The user must write
// registers through the cfg port only while no tick is in flight; the block does
// not enforce it. Index 0 to 6 are dead zone, slow, medium and fast limits,
// debounce time, report period and circle period, and any other index is ignored.
module tilt_mouse_delta_generator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [0] button_level, [1] host_ready, [17:2] accel_x, [33:18] accel_y, rest zero
  input  logic [tmdg_pkg::InDataW-1:0]   s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [0] report_valid, [5:1] delta_x, [10:6] delta_y, [11] circle_mode, rest zero
  output logic [tmdg_pkg::OutDataW-1:0]  m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tmdg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tmdg_pkg::CfgDataW-1:0]  cfg_data
);
  import tmdg_pkg::*;

  cfg_t cfg;

  logic              in_full;
  logic              in_button;
  logic              in_host_ready;
  logic [RawW-1:0]   in_accel_x;
  logic [RawW-1:0]   in_accel_y;
  logic              out_full;
  logic              out_free;
  logic              advance;

  logic [TimeW-1:0]  time_now;
  logic [TimeW-1:0]  report_start;
  logic [TimeW-1:0]  circle_start;
  logic [TimeW-1:0]  press_time;
  logic              button_prev;
  logic              mode_flag;
  logic [StepW-1:0]  circle_step;

  logic              press;
  logic              mode_next;
  logic              report_due;
  logic              circle_due;
  logic              send;
  logic              step_circle;
  logic [StepW-1:0]  circle_step_next;
  logic [TableIdxW-1:0] ring_idx;
  delta_t            tilt_dx;
  delta_t            tilt_dy;
  delta_t            dx;
  delta_t            dy;

  tmdg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tmdg_quant u_quant_x (
    .raw    (in_accel_x),
    .negate (1'b0),
    .cfg    (cfg),
    .delta  (tilt_dx)
  );

  // The Y axis is reported with the opposite sign.
  tmdg_quant u_quant_y (
    .raw    (in_accel_y),
    .negate (1'b1),
    .cfg    (cfg),
    .delta  (tilt_dy)
  );

  assign out_free = !out_full || m_tready;
  assign advance  = in_full && out_free;
  assign s_tready = !in_full || out_free;
  assign m_tvalid = out_full;

  assign press      = button_prev && !in_button &&
                      ((time_now - press_time) > {16'd0, cfg.debounce_ms});
  assign mode_next  = mode_flag ^ press;
  assign report_due = (time_now - report_start) >= {22'd0, cfg.report_period};
  assign circle_due = (time_now - circle_start) >= {18'd0, cfg.circle_period};
  assign send       = report_due && in_host_ready;
  assign step_circle = send && mode_next && circle_due;
  assign ring_idx   = ring_index(circle_step);
  assign circle_step_next = (circle_step == StepW'(CircleSteps - 1)) ?
                            '0 : circle_step + 1'b1;

  always_comb begin
    dx = '0;
    dy = '0;
    if (send && !mode_next) begin
      dx = tilt_dx;
      dy = tilt_dy;
    end else if (step_circle) begin
      dx = RingDx[ring_idx];
      dy = RingDy[ring_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (s_tready) begin
      in_full <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_button     <= s_tdata[0];
      in_host_ready <= s_tdata[1];
      in_accel_x    <= s_tdata[17:2];
      in_accel_y    <= s_tdata[33:18];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full     <= 1'b0;
      time_now     <= '0;
      report_start <= '0;
      circle_start <= '0;
      press_time   <= '0;
      button_prev  <= 1'b1;
      mode_flag    <= 1'b0;
      circle_step  <= '0;
    end else begin
      if (out_free) begin
        out_full <= in_full;
      end
      if (advance) begin
        time_now    <= time_now + 1'b1;
        button_prev <= in_button;
        mode_flag   <= mode_next;
        if (press) begin
          press_time <= time_now;
        end
        if (report_due) begin
          report_start <= report_start + {22'd0, cfg.report_period};
        end
        if (step_circle) begin
          circle_start <= circle_start + {18'd0, cfg.circle_period};
          circle_step  <= circle_step_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {4'd0, mode_next, dy, dx, send};
    end
  end

  // A tick that sends no report carries zero movement.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[10:1] == '0))
    else $error("movement without a report");

  assert property (@(posedge clk) disable iff (rst)
    advance |=> (time_now == $past(time_now) + 1'b1))
    else $error("tick counter did not step with an item");

  assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(mode_flag) && $stable(time_now) && $stable(circle_step)))
    else $error("state moved without an item");

  assert property (@(posedge clk) disable iff (rst)
    !out_full |-> s_tready)
    else $error("input stalled with an empty output stage");

  assert property (@(posedge clk) disable iff (rst)
    (advance && !press) |=> (mode_flag == $past(mode_flag)))
    else $error("mode changed without an accepted press");

endmodule

[rtl/tmdg_cfg.sv]
module tmdg_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tmdg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tmdg_pkg::CfgDataW-1:0]  cfg_data,
  output tmdg_pkg::cfg_t                 cfg
);
  import tmdg_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone     <= 16'd1311;
      cfg.slow_limit    <= 16'd4096;
      cfg.medium_limit  <= 16'd8192;
      cfg.fast_limit    <= 16'd12288;
      cfg.debounce_ms   <= 16'd200;
      cfg.report_period <= 10'd10;
      cfg.circle_period <= 14'd100;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEAD_ZONE:     cfg.dead_zone     <= cfg_data;
        REG_SLOW_LIMIT:    cfg.slow_limit    <= cfg_data;
        REG_MEDIUM_LIMIT:  cfg.medium_limit  <= cfg_data;
        REG_FAST_LIMIT:    cfg.fast_limit    <= cfg_data;
        REG_DEBOUNCE_MS:   cfg.debounce_ms   <= cfg_data;
        REG_REPORT_PERIOD: cfg.report_period <= cfg_data[9:0];
        REG_CIRCLE_PERIOD: cfg.circle_period <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/tmdg_quant.sv]
module tmdg_quant (
  input  logic [tmdg_pkg::RawW-1:0] raw,
  input  logic                      negate,
  input  tmdg_pkg::cfg_t            cfg,
  output tmdg_pkg::delta_t          delta
);
  import tmdg_pkg::*;

  logic          neg;
  logic [RawW:0] mag;
  delta_t        speed;

  // Full negative scale has a magnitude of 32768, so the top bit of mag stays zero.
  assign neg = raw[RawW-1];
  assign mag = neg ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};

  always_comb begin
    if (mag < {1'b0, cfg.slow_limit}) begin
      speed = 5'sd2;
    end else if (mag < {1'b0, cfg.medium_limit}) begin
      speed = 5'sd5;
    end else if (mag < {1'b0, cfg.fast_limit}) begin
      speed = 5'sd8;
    end else begin
      speed = 5'sd12;
    end
    if (mag < {1'b0, cfg.dead_zone}) begin
      delta = '0;
    end else if (neg ^ negate) begin
      delta = -speed;
    end else begin
      delta = speed;
    end
  end

endmodule
